>>> design/fbt_pkg.sv
`timescale 1ns / 1ps
// Shared widths, step counts, command and status types for the F1 tracker.
package fbt_pkg;

  localparam int COUNT_BITS    = 32;
  localparam int FRACTION_BITS = 16;

  localparam int FIELD_W = 32;
  localparam int WIDE_W  = 2 * FIELD_W;
  localparam int CODE_W  = 32;
  localparam int Q_W     = FRACTION_BITS + 1;
  localparam int NUM_W   = COUNT_BITS + 1;
  localparam int DEN_W   = COUNT_BITS + 3;
  localparam int DIV_W   = DEN_W;

  localparam int DIV_STEPS = FRACTION_BITS + 1;
  localparam int MUL_STEPS = (NUM_W + 1) / 2;
  localparam int MPLR_W    = 2 * MUL_STEPS;
  localparam int PROD_W    = DEN_W + MPLR_W;
  localparam int RUN_STEPS = (DIV_STEPS > MUL_STEPS) ? DIV_STEPS : MUL_STEPS;
  localparam int STEP_W    = $clog2(RUN_STEPS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } fbt_state_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic              finish;
    logic [STEP_W-1:0] idx;
  } fbt_cmd_t;

  typedef struct packed {
    logic out_free;
  } fbt_sts_t;

endpackage

>>> design/fbt_div.sv
`timescale 1ns / 1ps
// Restoring fractional divider, one quotient bit per step.
module fbt_div (
  input  logic                      clk,
  input  logic                      load,
  input  logic                      step,
  input  logic [fbt_pkg::DIV_W-1:0] num,
  input  logic [fbt_pkg::DIV_W-1:0] den,
  output logic [fbt_pkg::Q_W-1:0]   quo
);

  logic [fbt_pkg::DIV_W:0]   rem;
  logic [fbt_pkg::DIV_W-1:0] dvs;
  logic                      ge;
  logic [fbt_pkg::DIV_W:0]   rem_sub;

  assign ge      = rem >= (fbt_pkg::DIV_W + 1)'(dvs);
  assign rem_sub = ge ? (rem - (fbt_pkg::DIV_W + 1)'(dvs)) : rem;

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= (fbt_pkg::DIV_W + 1)'(num);
      dvs <= den;
      quo <= '0;
    end else if (step) begin
      rem <= {rem_sub[fbt_pkg::DIV_W-1:0], 1'b0};
      quo <= {quo[fbt_pkg::Q_W-2:0], ge};
    end
  end

endmodule

>>> design/fbt_mul.sv
`timescale 1ns / 1ps
// Radix-4 shift-add multiplier, two multiplier bits per step.
module fbt_mul (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       step,
  input  logic [fbt_pkg::NUM_W-1:0]  mplr,
  input  logic [fbt_pkg::DEN_W-1:0]  mcand,
  output logic [fbt_pkg::PROD_W-1:0] prod
);

  logic [fbt_pkg::MPLR_W-1:0] mreg;
  logic [fbt_pkg::DEN_W-1:0]  mc;
  logic [fbt_pkg::DEN_W+1:0]  pp;
  logic [fbt_pkg::DEN_W+1:0]  sum;

  assign pp  = (mreg[0] ? (fbt_pkg::DEN_W + 2)'(mc) : '0)
             + (mreg[1] ? {1'b0, mc, 1'b0} : '0);
  assign sum = (fbt_pkg::DEN_W + 2)'(prod[fbt_pkg::PROD_W-1:fbt_pkg::MPLR_W]) + pp;

  always_ff @(posedge clk) begin
    if (load) begin
      mreg <= fbt_pkg::MPLR_W'(mplr);
      mc   <= mcand;
      prod <= '0;
    end else if (step) begin
      mreg <= mreg >> 2;
      prod <= {sum, prod[fbt_pkg::MPLR_W-1:2]};
    end
  end

endmodule

>>> design/fbt_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences load, serial steps and result write-back.
module fbt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  fbt_pkg::fbt_sts_t sts,
  output fbt_pkg::fbt_cmd_t cmd
);

  fbt_pkg::fbt_state_t         state;
  fbt_pkg::fbt_state_t         state_next;
  logic [fbt_pkg::STEP_W-1:0]  idx;
  logic                        last_step;

  assign last_step = idx == fbt_pkg::STEP_W'(fbt_pkg::RUN_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbt_pkg::ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.step) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fbt_pkg::ST_IDLE: begin
        if (in_valid) state_next = fbt_pkg::ST_RUN;
      end
      fbt_pkg::ST_RUN: begin
        if (last_step) state_next = fbt_pkg::ST_FINISH;
      end
      fbt_pkg::ST_FINISH: begin
        if (sts.out_free) state_next = fbt_pkg::ST_IDLE;
      end
      default: state_next = fbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    cmd.idx    = idx;
    case (state)
      fbt_pkg::ST_IDLE: begin
        in_stall = rst;
        cmd.load = in_valid && !rst;
      end
      fbt_pkg::ST_RUN: begin
        cmd.step = 1'b1;
      end
      fbt_pkg::ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> design/fbt_datapath.sv
`timescale 1ns / 1ps
// Datapath: operand setup, dividers, cross multipliers, running best, result register.
module fbt_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  fbt_pkg::fbt_cmd_t                  cmd,
  output fbt_pkg::fbt_sts_t                  sts,
  input  logic                               cfg_write,
  input  logic [31:0]                        cfg_data,
  input  logic signed [fbt_pkg::CODE_W-1:0]  threshold_code,
  input  logic [fbt_pkg::FIELD_W-1:0]        true_positives,
  input  logic [fbt_pkg::FIELD_W-1:0]        false_positives,
  input  logic [fbt_pkg::FIELD_W-1:0]        false_negatives,
  input  logic                               first_point,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [fbt_pkg::Q_W-1:0]            point_f1,
  output logic [fbt_pkg::Q_W-1:0]            point_precision,
  output logic [fbt_pkg::Q_W-1:0]            point_recall,
  output logic                               precision_valid,
  output logic                               recall_valid,
  output logic                               f1_valid,
  output logic                               best_available,
  output logic signed [fbt_pkg::CODE_W-1:0]  best_threshold,
  output logic [fbt_pkg::Q_W-1:0]            best_f1,
  output logic signed [fbt_pkg::CODE_W-1:0]  equal_range_low,
  output logic signed [fbt_pkg::CODE_W-1:0]  equal_range_high
);

  logic [31:0]                        truth_count;

  logic [fbt_pkg::WIDE_W-1:0]         tp_wide;
  logic [fbt_pkg::WIDE_W-1:0]         fp_wide;
  logic [fbt_pkg::WIDE_W-1:0]         fn_wide;
  logic [fbt_pkg::COUNT_BITS-1:0]     tp;
  logic [fbt_pkg::COUNT_BITS-1:0]     fp;
  logic [fbt_pkg::COUNT_BITS-1:0]     fn;
  logic [fbt_pkg::NUM_W-1:0]          prec_den;
  logic [fbt_pkg::NUM_W-1:0]          rec_den;
  logic [fbt_pkg::NUM_W-1:0]          tp2;
  logic [fbt_pkg::DEN_W-1:0]          f1_den_raw;
  logic                               in_fv;
  logic [fbt_pkg::NUM_W-1:0]          in_num;
  logic [fbt_pkg::DEN_W-1:0]          in_den;
  logic                               clear_best;

  logic signed [fbt_pkg::CODE_W-1:0]  code;
  logic [fbt_pkg::NUM_W-1:0]          num;
  logic [fbt_pkg::DEN_W-1:0]          den;
  logic                               pv;
  logic                               rv;
  logic                               fv;

  logic                               have_best;
  logic [fbt_pkg::NUM_W-1:0]          best_numerator;
  logic [fbt_pkg::DEN_W-1:0]          best_denominator;
  logic signed [fbt_pkg::CODE_W-1:0]  best_code;
  logic [fbt_pkg::Q_W-1:0]            best_f1_value;
  logic signed [fbt_pkg::CODE_W-1:0]  range_low_code;
  logic signed [fbt_pkg::CODE_W-1:0]  range_high_code;

  logic                               have_best_next;
  logic [fbt_pkg::NUM_W-1:0]          best_numerator_next;
  logic [fbt_pkg::DEN_W-1:0]          best_denominator_next;
  logic signed [fbt_pkg::CODE_W-1:0]  best_code_next;
  logic [fbt_pkg::Q_W-1:0]            best_f1_value_next;
  logic signed [fbt_pkg::CODE_W-1:0]  range_low_code_next;
  logic signed [fbt_pkg::CODE_W-1:0]  range_high_code_next;

  logic                               div_step;
  logic                               mul_step;
  logic [fbt_pkg::Q_W-1:0]            prec_q;
  logic [fbt_pkg::Q_W-1:0]            rec_q;
  logic [fbt_pkg::Q_W-1:0]            f1_q;
  logic [fbt_pkg::Q_W-1:0]            f1_val;
  logic [fbt_pkg::PROD_W-1:0]         prod_cur;
  logic [fbt_pkg::PROD_W-1:0]         prod_best;
  logic                               cur_gt;
  logic                               cur_eq;

  assign tp_wide = fbt_pkg::WIDE_W'(true_positives);
  assign fp_wide = fbt_pkg::WIDE_W'(false_positives);
  assign fn_wide = fbt_pkg::WIDE_W'(false_negatives);
  assign tp      = tp_wide[fbt_pkg::COUNT_BITS-1:0];
  assign fp      = fp_wide[fbt_pkg::COUNT_BITS-1:0];
  assign fn      = fn_wide[fbt_pkg::COUNT_BITS-1:0];

  assign prec_den   = fbt_pkg::NUM_W'(tp) + fbt_pkg::NUM_W'(fp);
  assign rec_den    = fbt_pkg::NUM_W'(tp) + fbt_pkg::NUM_W'(fn);
  assign tp2        = {tp, 1'b0};
  assign f1_den_raw = fbt_pkg::DEN_W'(tp2) + fbt_pkg::DEN_W'(fp) + fbt_pkg::DEN_W'(fn);
  assign in_fv      = tp != '0;
  assign in_num     = in_fv ? tp2 : '0;
  assign in_den     = in_fv ? f1_den_raw : fbt_pkg::DEN_W'(1);
  assign clear_best = first_point || (truth_count == '0);

  assign div_step = cmd.step && (cmd.idx < fbt_pkg::STEP_W'(fbt_pkg::DIV_STEPS));
  assign mul_step = cmd.step && (cmd.idx < fbt_pkg::STEP_W'(fbt_pkg::MUL_STEPS));

  assign sts.out_free = !out_valid || !out_stall;

  fbt_div u_div_prec (
    .clk  (clk),
    .load (cmd.load),
    .step (div_step),
    .num  (fbt_pkg::DIV_W'(tp)),
    .den  (fbt_pkg::DIV_W'(prec_den)),
    .quo  (prec_q)
  );

  fbt_div u_div_rec (
    .clk  (clk),
    .load (cmd.load),
    .step (div_step),
    .num  (fbt_pkg::DIV_W'(tp)),
    .den  (fbt_pkg::DIV_W'(rec_den)),
    .quo  (rec_q)
  );

  fbt_div u_div_f1 (
    .clk  (clk),
    .load (cmd.load),
    .step (div_step),
    .num  (fbt_pkg::DIV_W'(in_num)),
    .den  (in_den),
    .quo  (f1_q)
  );

  fbt_mul u_mul_cur (
    .clk   (clk),
    .load  (cmd.load),
    .step  (mul_step),
    .mplr  (in_num),
    .mcand (best_denominator),
    .prod  (prod_cur)
  );

  fbt_mul u_mul_best (
    .clk   (clk),
    .load  (cmd.load),
    .step  (mul_step),
    .mplr  (best_numerator),
    .mcand (in_den),
    .prod  (prod_best)
  );

  assign cur_gt = prod_cur > prod_best;
  assign cur_eq = prod_cur == prod_best;
  assign f1_val = fv ? f1_q : '0;

  always_comb begin
    have_best_next        = have_best;
    best_numerator_next   = best_numerator;
    best_denominator_next = best_denominator;
    best_code_next        = best_code;
    best_f1_value_next    = best_f1_value;
    range_low_code_next   = range_low_code;
    range_high_code_next  = range_high_code;
    if (truth_count != '0) begin
      if (!have_best || cur_gt) begin
        have_best_next        = 1'b1;
        best_numerator_next   = num;
        best_denominator_next = den;
        best_code_next        = code;
        best_f1_value_next    = f1_val;
        range_low_code_next   = code;
        range_high_code_next  = code;
      end else if (cur_eq) begin
        if (code < range_low_code) range_low_code_next = code;
        if (code > range_high_code) range_high_code_next = code;
        if (code > best_code) begin
          best_code_next        = code;
          best_numerator_next   = num;
          best_denominator_next = den;
          best_f1_value_next    = f1_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      truth_count <= '0;
    end else if (cfg_write) begin
      truth_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code <= threshold_code;
      num  <= in_num;
      den  <= in_den;
      pv   <= prec_den != '0;
      rv   <= rec_den != '0;
      fv   <= in_fv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.load && clear_best)) begin
      have_best        <= 1'b0;
      best_numerator   <= '0;
      best_denominator <= fbt_pkg::DEN_W'(1);
      best_code        <= '0;
      best_f1_value    <= '0;
      range_low_code   <= '0;
      range_high_code  <= '0;
    end else if (cmd.finish) begin
      have_best        <= have_best_next;
      best_numerator   <= best_numerator_next;
      best_denominator <= best_denominator_next;
      best_code        <= best_code_next;
      best_f1_value    <= best_f1_value_next;
      range_low_code   <= range_low_code_next;
      range_high_code  <= range_high_code_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      point_f1         <= f1_val;
      point_precision  <= pv ? prec_q : '0;
      point_recall     <= rv ? rec_q : '0;
      precision_valid  <= pv;
      recall_valid     <= rv;
      f1_valid         <= fv;
      best_available   <= have_best_next;
      best_threshold   <= have_best_next ? best_code_next : '0;
      best_f1          <= have_best_next ? best_f1_value_next : '0;
      equal_range_low  <= have_best_next ? range_low_code_next : '0;
      equal_range_high <= have_best_next ? range_high_code_next : '0;
    end
  end

endmodule

>>> design/f1_best_threshold_tracker.sv
`timescale 1ns / 1ps
// F1 best-threshold tracker: top level joining controller and datapath.
// Each item passes load, 17 serial steps and write-back; write-back sets out_valid.
// No new item is taken until write-back; the 17 steps come from the bit-serial
// dividers (one quotient bit a step) and the radix-4 cross multipliers.
// A stalled result holds the next item in write-back until the output frees.
// Reset (rst, synchronous): clears the running best, the truth count and out_valid.
module f1_best_threshold_tracker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [31:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [fbt_pkg::CODE_W-1:0]  threshold_code,
  input  logic [fbt_pkg::FIELD_W-1:0]        true_positives,
  input  logic [fbt_pkg::FIELD_W-1:0]        false_positives,
  input  logic [fbt_pkg::FIELD_W-1:0]        false_negatives,
  input  logic                               first_point,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fbt_pkg::Q_W-1:0]            point_f1,
  output logic [fbt_pkg::Q_W-1:0]            point_precision,
  output logic [fbt_pkg::Q_W-1:0]            point_recall,
  output logic                               precision_valid,
  output logic                               recall_valid,
  output logic                               f1_valid,
  output logic                               best_available,
  output logic signed [fbt_pkg::CODE_W-1:0]  best_threshold,
  output logic [fbt_pkg::Q_W-1:0]            best_f1,
  output logic signed [fbt_pkg::CODE_W-1:0]  equal_range_low,
  output logic signed [fbt_pkg::CODE_W-1:0]  equal_range_high
);

  fbt_pkg::fbt_cmd_t cmd;
  fbt_pkg::fbt_sts_t sts;

  fbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fbt_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .threshold_code   (threshold_code),
    .true_positives   (true_positives),
    .false_positives  (false_positives),
    .false_negatives  (false_negatives),
    .first_point      (first_point),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .point_f1         (point_f1),
    .point_precision  (point_precision),
    .point_recall     (point_recall),
    .precision_valid  (precision_valid),
    .recall_valid     (recall_valid),
    .f1_valid         (f1_valid),
    .best_available   (best_available),
    .best_threshold   (best_threshold),
    .best_f1          (best_f1),
    .equal_range_low  (equal_range_low),
    .equal_range_high (equal_range_high)
  );

endmodule

>>> design/fbt_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the F1 tracker, bound to the top level.
module fbt_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [fbt_pkg::Q_W-1:0]            point_precision,
  input logic                               precision_valid,
  input logic                               recall_valid,
  input logic                               f1_valid,
  input logic                               best_available,
  input logic signed [fbt_pkg::CODE_W-1:0]  best_threshold,
  input logic [fbt_pkg::Q_W-1:0]            best_f1,
  input logic signed [fbt_pkg::CODE_W-1:0]  equal_range_low,
  input logic signed [fbt_pkg::CODE_W-1:0]  equal_range_high
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_f1_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && f1_valid |-> precision_valid && recall_valid)
    else $error("f1 defined without precision and recall");

  a_no_best_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !best_available |-> best_threshold == '0 && best_f1 == '0 &&
      equal_range_low == '0 && equal_range_high == '0 && (precision_valid || point_precision == '0))
    else $error("best fields nonzero without a best point");

  a_range_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && best_available |->
      equal_range_low <= best_threshold && best_threshold <= equal_range_high)
    else $error("best threshold outside its equal range");

endmodule

bind f1_best_threshold_tracker fbt_checker u_fbt_checker (.*);
